// ===== rtl/alsf_pkg.sv =====
// Shared types, constants and helpers for the acceleration limited setpoint follower.
package alsf_pkg;

  localparam int ALU_W      = 50;
  localparam int GAIN_W     = 16;
  localparam int ACCEL_W    = 31;
  localparam int DT_W       = 24;
  localparam int VAL_W      = 32;
  localparam int ERR_W      = VAL_W + 1;
  localparam int QUO_W      = 48;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam int IN_DATA_W  = 56;

  // 0.03 in Q8.16.
  localparam logic [DT_W-1:0] DT_LIMIT = 24'd1966;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = 1'b1;

  localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd256;
  localparam logic [ACCEL_W-1:0] MAX_ACCEL_RST = 31'd655;

  localparam logic [CNT_W-1:0] MUL_SHORT_CNT = 6'd16;
  localparam logic [CNT_W-1:0] MUL_LONG_CNT  = 6'd31;
  localparam logic [CNT_W-1:0] DIV_CNT       = 6'd48;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [ACCEL_W-1:0] max_accel;
  } alsf_cfg_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
    logic             cin;
  } alsf_alu_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_ADT,
    ST_AERR,
    ST_MUL1,
    ST_MUL2,
    ST_SAT,
    ST_SGN,
    ST_PABS,
    ST_CMP,
    ST_DIV1,
    ST_D1SGN,
    ST_DIV2,
    ST_ACC,
    ST_ABSA,
    ST_MUL3,
    ST_REB,
    ST_UPD,
    ST_DONE
  } alsf_state_t;

  // Clamp a wide two's complement value to the signed 32-bit range.
  function automatic logic [VAL_W-1:0] sat_val(input logic [ALU_W-1:0] x);
    logic fits;
    fits = (x[ALU_W-1:VAL_W-1] == '0) || (x[ALU_W-1:VAL_W-1] == '1);
    if (fits) begin
      return x[VAL_W-1:0];
    end else if (x[ALU_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/alsf_alu.sv =====
// Shared adder/subtractor used by the add, subtract, negate, multiply and divide steps of the sequencer.
module alsf_alu import alsf_pkg::*; (
  input  alsf_alu_req_t    req,
  output logic [ALU_W-1:0] y
);

  logic [ALU_W-1:0] b_eff;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign y     = req.a + b_eff + {{(ALU_W-1){1'b0}}, req.cin};

endmodule

// ===== rtl/alsf_core.sv =====
// Sequencer and datapath registers: shift-add multiplies, restoring divides, saturation.
module alsf_core import alsf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  alsf_cfg_t        cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [DT_W-1:0]  in_dt,
  input  logic [VAL_W-1:0] in_target,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [VAL_W-1:0] res_value
);

  alsf_state_t       st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DT_W-1:0]   dt_r, dt_nxt;
  logic [VAL_W-1:0]  tgt_r, tgt_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [VAL_W-1:0]  pstep_r, pstep_nxt;
  logic [DT_W-1:0]   pdt_r, pdt_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [DT_W-1:0]   dtmag_r, dtmag_nxt;
  logic [ERR_W-1:0]  mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [ERR_W-1:0]  hi_r, hi_nxt;
  logic [QUO_W-1:0]  lo_r, lo_nxt;
  logic [VAL_W-1:0]  stepmag_r, stepmag_nxt;
  logic [VAL_W-1:0]  step_r, step_nxt;
  logic [VAL_W-1:0]  pmag_r, pmag_nxt;
  logic [ALU_W-1:0]  racc_r, racc_nxt;
  logic              accneg_r, accneg_nxt;

  alsf_alu_req_t     alu_req;
  logic [ALU_W-1:0]  alu_y;

  logic [ERR_W-1:0]  mcand;
  logic [ERR_W:0]    mul_sum;
  logic [64:0]       mul_p;
  logic [DT_W-1:0]   div_d;
  logic [DT_W-1:0]   div_shift;
  logic              div_ok;
  logic [47:0]       pm;
  logic [ALU_W-1:0]  amag;
  logic              lim_go;

  alsf_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  // Multiplicand and divisor selection for the iterative states.
  always_comb begin
    mcand = (st_r == ST_MUL1) ? {{(ERR_W-DT_W){1'b0}}, dtmag_r} : mag_r;
    div_d = (st_r == ST_DIV2) ? pdt_r : dt_r;
  end

  assign div_shift = {hi_r[DT_W-2:0], lo_r[QUO_W-1]};
  assign div_ok    = ~alu_y[ALU_W-1];
  assign mul_sum   = alu_y[ERR_W:0];
  assign mul_p     = {mul_sum, lo_r[31:1]};
  assign pm        = {hi_r, lo_r[31:17]};
  assign amag      = racc_r[ALU_W-1] ? alu_y : racc_r;
  assign lim_go    = alu_y[ALU_W-1] && !dt_r[DT_W-1] && (dt_r != '0) &&
                     !pdt_r[DT_W-1] && (pdt_r != '0);

  // Operand routing into the shared unit.
  always_comb begin
    alu_req = '0;
    unique case (st_r)
      ST_ERR: begin
        alu_req.a   = {{(ALU_W-VAL_W){tgt_r[VAL_W-1]}}, tgt_r};
        alu_req.b   = {{(ALU_W-VAL_W){val_r[VAL_W-1]}}, val_r};
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      ST_ADT: begin
        alu_req.b   = {{(ALU_W-DT_W){dt_r[DT_W-1]}}, dt_r};
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      ST_AERR: begin
        alu_req.b   = {{(ALU_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      ST_MUL1, ST_MUL2, ST_MUL3: begin
        alu_req.a = {{(ALU_W-ERR_W){1'b0}}, hi_r};
        alu_req.b = lo_r[0] ? {{(ALU_W-ERR_W){1'b0}}, mcand} : '0;
      end
      ST_SGN: begin
        alu_req.b   = {{(ALU_W-VAL_W){1'b0}}, stepmag_r};
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      ST_PABS: begin
        alu_req.b   = {{(ALU_W-VAL_W){pstep_r[VAL_W-1]}}, pstep_r};
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      ST_CMP: begin
        alu_req.a   = {{(ALU_W-VAL_W){1'b0}}, pmag_r};
        alu_req.b   = {{(ALU_W-VAL_W){1'b0}}, stepmag_r};
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      ST_DIV1, ST_DIV2: begin
        alu_req.a   = {{(ALU_W-DT_W){1'b0}}, div_shift};
        alu_req.b   = {{(ALU_W-DT_W){1'b0}}, div_d};
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      ST_D1SGN: begin
        alu_req.b   = {{(ALU_W-QUO_W){1'b0}}, lo_r};
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      ST_ACC: begin
        // Subtract the old rate: add the quotient when the old step was negative.
        alu_req.a   = racc_r;
        alu_req.b   = {{(ALU_W-QUO_W){1'b0}}, lo_r};
        alu_req.sub = ~pstep_r[VAL_W-1];
        alu_req.cin = ~pstep_r[VAL_W-1];
      end
      ST_ABSA: begin
        alu_req.b   = racc_r;
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      ST_REB: begin
        // A negative acceleration floors: prev - q - 1 unless the dropped bits are zero.
        alu_req.a   = {{(ALU_W-VAL_W){pstep_r[VAL_W-1]}}, pstep_r};
        alu_req.b   = {{(ALU_W-ERR_W){1'b0}}, hi_r};
        alu_req.sub = accneg_r;
        alu_req.cin = accneg_r && (lo_r[31:16] == '0);
      end
      ST_UPD: begin
        alu_req.a = {{(ALU_W-VAL_W){val_r[VAL_W-1]}}, val_r};
        alu_req.b = {{(ALU_W-VAL_W){step_r[VAL_W-1]}}, step_r};
      end
      default: begin
      end
    endcase
  end

  // Next state and datapath updates.
  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    dt_nxt      = dt_r;
    tgt_nxt     = tgt_r;
    val_nxt     = val_r;
    pstep_nxt   = pstep_r;
    pdt_nxt     = pdt_r;
    err_nxt     = err_r;
    dtmag_nxt   = dtmag_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    stepmag_nxt = stepmag_r;
    step_nxt    = step_r;
    pmag_nxt    = pmag_r;
    racc_nxt    = racc_r;
    accneg_nxt  = accneg_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            val_nxt   = in_target;
            pstep_nxt = '0;
            pdt_nxt   = '0;
            st_nxt    = ST_DONE;
          end else begin
            dt_nxt  = ($signed(in_dt) > $signed(DT_LIMIT)) ? DT_LIMIT : in_dt;
            tgt_nxt = in_target;
            st_nxt  = ST_ERR;
          end
        end
      end
      ST_ERR: begin
        err_nxt = alu_y[ERR_W-1:0];
        st_nxt  = ST_ADT;
      end
      ST_ADT: begin
        dtmag_nxt = dt_r[DT_W-1] ? alu_y[DT_W-1:0] : dt_r;
        st_nxt    = ST_AERR;
      end
      ST_AERR: begin
        mag_nxt = err_r[ERR_W-1] ? alu_y[ERR_W-1:0] : err_r;
        neg_nxt = dt_r[DT_W-1] ^ err_r[ERR_W-1];
        hi_nxt  = '0;
        lo_nxt  = {{(QUO_W-GAIN_W){1'b0}}, cfg.gain};
        cnt_nxt = MUL_SHORT_CNT;
        st_nxt  = ST_MUL1;
      end
      ST_MUL1: begin
        if (cnt_r == CNT_W'(1)) begin
          // gain * |dt| / 2^8 becomes the multiplier of the second product.
          hi_nxt  = '0;
          lo_nxt  = {{(QUO_W-31){1'b0}}, mul_p[54:24]};
          cnt_nxt = MUL_LONG_CNT;
          st_nxt  = ST_MUL2;
        end else begin
          hi_nxt  = mul_sum[ERR_W:1];
          lo_nxt  = {{(QUO_W-32){1'b0}}, mul_sum[0], lo_r[31:1]};
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_MUL2, ST_MUL3: begin
        hi_nxt  = mul_sum[ERR_W:1];
        lo_nxt  = {{(QUO_W-32){1'b0}}, mul_sum[0], lo_r[31:1]};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          st_nxt = (st_r == ST_MUL2) ? ST_SAT : ST_REB;
        end
      end
      ST_SAT: begin
        if (!neg_r) begin
          stepmag_nxt = (pm[47:31] != '0) ? {1'b0, {(VAL_W-1){1'b1}}} : pm[31:0];
        end else begin
          stepmag_nxt = ((pm[47:32] != '0) || (pm[31] && (pm[30:0] != '0))) ?
                        {1'b1, {(VAL_W-1){1'b0}}} : pm[31:0];
        end
        st_nxt = ST_SGN;
      end
      ST_SGN: begin
        step_nxt = neg_r ? alu_y[VAL_W-1:0] : stepmag_r;
        st_nxt   = (cfg.max_accel != '0) ? ST_PABS : ST_UPD;
      end
      ST_PABS: begin
        pmag_nxt = pstep_r[VAL_W-1] ? alu_y[VAL_W-1:0] : pstep_r;
        st_nxt   = ST_CMP;
      end
      ST_CMP: begin
        if (lim_go) begin
          hi_nxt  = '0;
          lo_nxt  = {stepmag_r, 16'd0};
          cnt_nxt = DIV_CNT;
          st_nxt  = ST_DIV1;
        end else begin
          pstep_nxt = step_r;
          pdt_nxt   = dt_r;
          st_nxt    = ST_UPD;
        end
      end
      ST_DIV1, ST_DIV2: begin
        hi_nxt  = {{(ERR_W-DT_W+1){1'b0}},
                   (div_ok ? alu_y[DT_W-2:0] : div_shift[DT_W-2:0])};
        lo_nxt  = {lo_r[QUO_W-2:0], div_ok};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          st_nxt = (st_r == ST_DIV1) ? ST_D1SGN : ST_ACC;
        end
      end
      ST_D1SGN: begin
        racc_nxt = step_r[VAL_W-1] ? alu_y : {{(ALU_W-QUO_W){1'b0}}, lo_r};
        hi_nxt   = '0;
        lo_nxt   = {pmag_r, 16'd0};
        cnt_nxt  = DIV_CNT;
        st_nxt   = ST_DIV2;
      end
      ST_ACC: begin
        racc_nxt = alu_y;
        st_nxt   = ST_ABSA;
      end
      ST_ABSA: begin
        accneg_nxt = racc_r[ALU_W-1];
        mag_nxt    = (amag > {{(ALU_W-ACCEL_W){1'b0}}, cfg.max_accel}) ?
                     {{(ERR_W-ACCEL_W){1'b0}}, cfg.max_accel} :
                     {{(ERR_W-ACCEL_W){1'b0}}, amag[ACCEL_W-1:0]};
        hi_nxt     = '0;
        lo_nxt     = {{(QUO_W-16){1'b0}}, dt_r[15:0]};
        cnt_nxt    = MUL_SHORT_CNT;
        st_nxt     = ST_MUL3;
      end
      ST_REB: begin
        step_nxt  = sat_val(alu_y);
        pstep_nxt = sat_val(alu_y);
        pdt_nxt   = dt_r;
        st_nxt    = ST_UPD;
      end
      ST_UPD: begin
        val_nxt = sat_val(alu_y);
        st_nxt  = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_value = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      val_r   <= '0;
      pstep_r <= '0;
      pdt_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      val_r   <= val_nxt;
      pstep_r <= pstep_nxt;
      pdt_r   <= pdt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    dt_r      <= dt_nxt;
    tgt_r     <= tgt_nxt;
    err_r     <= err_nxt;
    dtmag_r   <= dtmag_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    stepmag_r <= stepmag_nxt;
    step_r    <= step_nxt;
    pmag_r    <= pmag_nxt;
    racc_r    <= racc_nxt;
    accneg_r  <= accneg_nxt;
  end

  a_reset_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode) |=>
      (st_r == ST_DONE && pstep_r == '0 && pdt_r == '0))
    else $error("reset word did not clear history");

  a_dt_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE && st_r != ST_DONE) |-> ($signed(dt_r) <= $signed(DT_LIMIT)))
    else $error("time step above limit inside an update");

  a_div_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV1) |->
      (!dt_r[DT_W-1] && dt_r != '0 && !pdt_r[DT_W-1] && pdt_r != '0))
    else $error("divide entered with a non-positive time step");

  a_hist_off: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_UPD && cfg.max_accel == '0) |-> $stable(pstep_r))
    else $error("history changed with limiting disabled");

endmodule

// ===== rtl/accel_limited_setpoint_follower.sv =====
// Acceleration limited setpoint follower: config registers, output register, core.
// A reset word loads the value directly. An advance word runs the sequencer; with limiting on it
// also checks the limit, and runs the acceleration limit path only when it engages (two
// 48-step divides and three shift-add multiplies, all on one shared 50-bit adder).
// One word at a time: the next is accepted in the cycle after the result is handed off.
// Synchronous rst_n zeroes value and history and loads default config.
module accel_limited_setpoint_follower import alsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // delta_time [23:0], target_value [55:24]
  input  logic                  in_tuser,   // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VAL_W-1:0]      out_tdata,  // current_value [31:0]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  alsf_cfg_t        cfg_r, cfg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_data_r, out_data_nxt;
  logic             res_valid;
  logic             res_ready;
  logic [VAL_W-1:0] res_value;

  alsf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_dt     (in_tdata[DT_W-1:0]),
    .in_target (in_tdata[DT_W+VAL_W-1:DT_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_value (res_value)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN:      cfg_nxt.gain      = cfg_wdata[GAIN_W-1:0];
        REG_MAX_ACCEL: cfg_nxt.max_accel = cfg_wdata[ACCEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The output register frees the core as soon as the word is stored.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_value;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain      <= GAIN_RST;
      cfg_r.max_accel <= MAX_ACCEL_RST;
      out_valid_r     <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
